FILE: sv/sha1sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared types and constants for the SHA-1 hasher and its compression core.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    typedef logic [31:0]        t_word;
    typedef logic [15:0][31:0]  t_block;
    typedef logic [4:0][31:0]   t_chain;

    // Status that the compression core reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    localparam t_chain H_INIT = '{
        0: 32'h67452301,
        1: 32'hEFCDAB89,
        2: 32'h98BADCFE,
        3: 32'h10325476,
        4: 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

FILE: sv/sha1sh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher channels
// Request channel for message bytes and result channel for digest words.
// ----------------------------------------------------------------------------
interface sha1sh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source(output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
    modport sink(input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

interface sha1sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source(output valid, output digest_word, output word_index,
                   output last_word, input ready);
    modport sink(input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

FILE: sv/sha1sh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 compression core
// One round per cycle for 80 rounds, with a 16-word schedule shift line.
// ----------------------------------------------------------------------------
module sha1sh_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  sha1sh_pkg::t_block     i_block,
    input  sha1sh_pkg::t_chain     i_chain,
    output sha1sh_pkg::t_core_stat o_stat,
    output sha1sh_pkg::t_chain     o_vars
);
    import sha1sh_pkg::*;

    function automatic t_word rotl(input t_word v, input logic [4:0] s);
        rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
    endfunction

    logic       r_busy;
    logic       r_done;
    logic [6:0] r_cnt;
    t_block     r_w;
    t_chain     r_v;

    t_word n_f;
    t_word n_k;
    t_word n_tmp;
    t_word n_wnext;

    always_comb begin
        if (r_cnt < ROUND_B1) begin
            n_f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            n_k = K_0;
        end else if (r_cnt < ROUND_B2) begin
            n_f = r_v[1] ^ r_v[2] ^ r_v[3];
            n_k = K_1;
        end else if (r_cnt < ROUND_B3) begin
            n_f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            n_k = K_2;
        end else begin
            n_f = r_v[1] ^ r_v[2] ^ r_v[3];
            n_k = K_3;
        end
        n_tmp   = rotl(r_v[0], 5'd5) + n_f + r_v[4] + n_k + r_w[0];
        // r_w[0] holds the word of this round; slot 15 takes the word 16 ahead.
        n_wnext = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_block;
            r_v <= i_chain;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_wnext;
            r_v[4]  <= r_v[3];
            r_v[3]  <= r_v[2];
            r_v[2]  <= rotl(r_v[1], 5'd30);
            r_v[1]  <= r_v[0];
            r_v[0]  <= n_tmp;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_vars      = r_v;

endmodule

FILE: sv/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Packs a byte stream into 512-bit blocks, compresses each block with an
// iterative round core, pads at end of message and returns five digest words.
// ----------------------------------------------------------------------------
//
//  Port    | Dir | Carries                                        | Per request
//  --------+-----+------------------------------------------------+------------
//  i_in    | in  | data_byte, byte_present, end_of_message        | one byte
//  o_out   | out | digest_word, word_index, last_word             | one word
//
// A byte that does not complete a block leaves the block idle and ready for
// the next byte, unless it ends the message. A byte that completes a 64-byte
// block keeps the block busy while it hands the block to the round core, runs
// the 80 rounds at one per cycle, and folds the result into the chain.
// The round core is the single shared unit.
// End of message takes a padding step, a length step and one more
// compression, plus another compression when the padding does not fit
// in the current block, then five digest words, each held until taken.
// Reset is synchronous and active low; it loads the initial chain value and
// clears the byte buffer and the length. After the fifth word is taken the
// block returns to that same state for the next message.
// i_in.ready is high only while the sequencer is idle; a stall on o_out just
// holds the current digest word.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1sh_in_if.sink   i_in,
    sha1sh_out_if.source o_out
);
    import sha1sh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_PAD  = 5'b00100,
        S_LEN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // What follows the running compression.
    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_PAD   = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    t_chain      r_h;
    t_block      r_blk;
    logic [63:0] r_len;
    logic        r_eom;
    logic        r_start;
    logic [2:0]  r_oidx;

    t_core_stat  w_stat;
    t_chain      w_vars;

    logic [5:0]  n_pos;
    logic [3:0]  n_widx;
    logic [4:0]  n_shift;

    // The byte position in the current block follows bits 8..3 of the length.
    assign n_pos   = r_len[8:3];
    assign n_widx  = n_pos[5:2];
    assign n_shift = {~n_pos[1:0], 3'b000};

    sha1sh_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_block(r_blk),
        .i_chain(r_h),
        .o_stat (w_stat),
        .o_vars (w_vars)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_h     <= H_INIT;
            r_blk   <= '0;
            r_len   <= '0;
            r_eom   <= 1'b0;
            r_start <= 1'b0;
            r_oidx  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_eom <= i_in.end_of_message;
                        if (i_in.byte_present) begin
                            // The buffer word is zero past the fill point, so
                            // an OR places the byte.
                            r_blk[n_widx] <= r_blk[n_widx]
                                           | ({24'd0, i_in.data_byte} << n_shift);
                            r_len <= r_len + 64'd8;
                            if (n_pos == LAST_BYTE_POS) begin
                                r_start <= 1'b1;
                                r_phase <= PH_DATA;
                                r_state <= S_CMP;
                            end else if (i_in.end_of_message) begin
                                r_state <= S_PAD;
                            end
                        end else if (i_in.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_CMP: begin
                    if (r_start) begin
                        // The core took the block at this edge.
                        r_start <= 1'b0;
                        r_blk   <= '0;
                    end
                    if (w_stat.done) begin
                        for (int i = 0; i < 5; i++) begin
                            r_h[i] <= r_h[i] + w_vars[i];
                        end
                        case (r_phase)
                            PH_DATA:  r_state <= r_eom ? S_PAD : S_IDLE;
                            PH_PAD:   r_state <= S_LEN;
                            PH_FINAL: begin
                                r_oidx  <= '0;
                                r_state <= S_OUT;
                            end
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PAD: begin
                    r_blk[n_widx] <= r_blk[n_widx] | ({24'd0, PAD_BYTE} << n_shift);
                    if (n_pos >= LEN_BYTE_POS) begin
                        // No room for the length: compress and use a fresh block.
                        r_start <= 1'b1;
                        r_phase <= PH_PAD;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_blk[14] <= r_len[63:32];
                    r_blk[15] <= r_len[31:0];
                    r_start   <= 1'b1;
                    r_phase   <= PH_FINAL;
                    r_state   <= S_CMP;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        if (r_oidx == LAST_WORD_IDX) begin
                            r_h     <= H_INIT;
                            r_len   <= '0;
                            r_eom   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = r_h[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == LAST_WORD_IDX);

    // The round core is never running while new bytes are taken.
    a_idle_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stat.busy)
        else $error("round core busy while accepting bytes");

    // A compression result always moves the sequencer out of the wait state.
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |=> (r_state != S_CMP))
        else $error("sequencer missed a compression result");

    // Digest words never go past the fifth word.
    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.word_index <= LAST_WORD_IDX))
        else $error("digest word index out of range");

    // After the last word is taken, the next message starts from zero length.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word)
            |=> (r_len == 64'd0) && (r_state == S_IDLE))
        else $error("state not restored after digest");

    // A core start is only ever issued from the compression wait state.
    a_start_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_CMP) && !w_stat.busy)
        else $error("core start outside compression wait");

endmodule
